FILE: hw/rtl/wcsp_pkg.sv
`default_nettype none
package wcsp_pkg;
  typedef enum logic [2:0] {
    PH_HDR, PH_CHUNK, PH_FMT, PH_SKIP, PH_DATA, PH_DIV, PH_HALT
  } phase_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] SIZE_INDET = 32'hffff_ffff;
  localparam logic [31:0] FMT_MIN_BYTES = 32'd16;
  localparam logic [31:0] INDET_RESET = 32'd10000000;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NOT_RIFF   = 3'd0;
  localparam logic [2:0] ERR_NOT_WAVE   = 3'd1;
  localparam logic [2:0] ERR_FMT_SMALL  = 3'd2;
  localparam logic [2:0] ERR_PCM_BITS   = 3'd3;
  localparam logic [2:0] ERR_FLOAT_BITS = 3'd4;
  localparam logic [2:0] ERR_FORMAT     = 3'd5;
  localparam logic [2:0] ERR_ALIGN      = 3'd6;

  typedef struct packed {
    logic take;        // accept byte and update state
    logic div_start;
    logic emit_sample;
    logic emit_report;
    logic emit_error;
    logic [2:0] err;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/wcsp_divider.sv
`default_nettype none
module wcsp_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  logic [31:0] quo;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [5:0]  cnt;
  logic [16:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};
  assign busy = (cnt != 6'd0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (start) begin
      cnt <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= 16'd0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[16] || rem[15]) begin
        rem <= trial[15:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[14:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/wcsp_datapath.sv
`default_nettype none
module wcsp_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wcsp_pkg::cmd_t    cmd,
  output wcsp_pkg::sts_t         sts,
  input  wire logic [7:0]        data_byte,
  input  wire logic [31:0]       indet_frames,
  input  wire wcsp_pkg::phase_t  phase,
  output wcsp_pkg::phase_t       phase_next,
  output logic                   fire,
  output logic [2:0]             fire_err,
  output logic                   fire_report,
  output logic [31:0]            sample_val,
  output logic [15:0]            fmt_o,
  output logic [15:0]            chan_o,
  output logic [31:0]            rate_o,
  output logic [31:0]            frames_o
);
  logic [31:0] byte_counter, id_shift, chunk_length, rate_held;
  logic [15:0] format_code, channels_held, align_held, bits_held;
  logic [31:0] samples_left, skip_left, sample_shift;
  logic        hdr_bad;
  logic [31:0] id_nx, len_nx, ss_nx, bc_inc, quo;
  logic [31:0] chan32, need_align;
  logic        div_busy;

  assign id_nx  = {data_byte, id_shift[31:8]};
  assign len_nx = {data_byte, chunk_length[31:8]};
  assign ss_nx  = {data_byte, sample_shift[31:8]};
  assign bc_inc = byte_counter + 32'd1;
  assign chan32 = {16'd0, channels_held};
  assign need_align = (format_code == 16'd1) ? {chan32[30:0], 1'b0} : {chan32[29:0], 2'b00};
  assign sts.div_busy = div_busy;
  assign fmt_o = format_code;
  assign chan_o = channels_held;
  assign rate_o = rate_held;

  wcsp_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(chunk_length), .divisor(align_held),
    .busy(div_busy), .quotient(quo)
  );

  // decide per-phase outcome of the incoming byte, or of the finished division in PH_DIV
  always_comb begin
    phase_next = phase;
    fire = 1'b0;
    fire_err = wcsp_pkg::ERR_NOT_RIFF;
    fire_report = 1'b0;
    sample_val = (format_code == 16'd1) ?
      {{16{ss_nx[31]}}, ss_nx[31:16]} : ss_nx;
    case (phase)
      wcsp_pkg::PH_HDR: begin
        if (byte_counter[3:0] == 4'd11) begin
          if (hdr_bad) begin
            fire = 1'b1; fire_err = wcsp_pkg::ERR_NOT_RIFF;
            phase_next = wcsp_pkg::PH_HALT;
          end else if (id_nx != wcsp_pkg::TAG_WAVE) begin
            fire = 1'b1; fire_err = wcsp_pkg::ERR_NOT_WAVE;
            phase_next = wcsp_pkg::PH_HALT;
          end else begin
            phase_next = wcsp_pkg::PH_CHUNK;
          end
        end
      end
      wcsp_pkg::PH_CHUNK: begin
        if (byte_counter[2:0] == 3'd7) begin
          if (id_shift == wcsp_pkg::TAG_FMT) begin
            if (len_nx < wcsp_pkg::FMT_MIN_BYTES) begin
              fire = 1'b1; fire_err = wcsp_pkg::ERR_FMT_SMALL;
              phase_next = wcsp_pkg::PH_HALT;
            end else begin
              phase_next = wcsp_pkg::PH_FMT;
            end
          end else if (id_shift == wcsp_pkg::TAG_DATA) begin
            if (format_code == 16'd1 && bits_held != 16'd16) begin
              fire = 1'b1; fire_err = wcsp_pkg::ERR_PCM_BITS;
              phase_next = wcsp_pkg::PH_HALT;
            end else if (format_code == 16'd3 && bits_held != 16'd32) begin
              fire = 1'b1; fire_err = wcsp_pkg::ERR_FLOAT_BITS;
              phase_next = wcsp_pkg::PH_HALT;
            end else if (format_code != 16'd1 && format_code != 16'd3) begin
              fire = 1'b1; fire_err = wcsp_pkg::ERR_FORMAT;
              phase_next = wcsp_pkg::PH_HALT;
            end else if (align_held == 16'd0 || {16'd0, align_held} != need_align) begin
              fire = 1'b1; fire_err = wcsp_pkg::ERR_ALIGN;
              phase_next = wcsp_pkg::PH_HALT;
            end else begin
              phase_next = wcsp_pkg::PH_DIV;
            end
          end else if (len_nx != 32'd0) begin
            phase_next = wcsp_pkg::PH_SKIP;
          end
        end
      end
      wcsp_pkg::PH_FMT: begin
        if (byte_counter[3:0] == 4'd15) begin
          phase_next = (skip_left != 32'd0) ? wcsp_pkg::PH_SKIP : wcsp_pkg::PH_CHUNK;
        end
      end
      wcsp_pkg::PH_SKIP: begin
        if (skip_left <= 32'd1) phase_next = wcsp_pkg::PH_CHUNK;
      end
      wcsp_pkg::PH_DATA: begin
        if (((format_code == 16'd1) ? (byte_counter[0] == 1'b1)
                                    : (byte_counter[1:0] == 2'b11))) begin
          fire = 1'b1;
          if (bc_inc >= {16'd0, align_held} && samples_left <= 32'd1)
            phase_next = wcsp_pkg::PH_CHUNK;
        end
      end
      wcsp_pkg::PH_DIV: begin
        fire_report = 1'b1;
        phase_next = (frames_o == 32'd0) ? wcsp_pkg::PH_CHUNK : wcsp_pkg::PH_DATA;
      end
      default: ;
    endcase
  end

  assign frames_o = (chunk_length == wcsp_pkg::SIZE_INDET) ? indet_frames : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter <= 32'd0; id_shift <= 32'd0; chunk_length <= 32'd0;
      format_code <= 16'd0; channels_held <= 16'd0; rate_held <= 32'd0;
      align_held <= 16'd0; bits_held <= 16'd0; samples_left <= 32'd0;
      skip_left <= 32'd0; sample_shift <= 32'd0; hdr_bad <= 1'b0;
    end else if (cmd.emit_report) begin
      samples_left <= frames_o;
      byte_counter <= 32'd0;
      sample_shift <= 32'd0;
    end else if (cmd.take) begin
      byte_counter <= bc_inc;
      case (phase)
        wcsp_pkg::PH_HDR: begin
          if (byte_counter < 32'd4 || byte_counter >= 32'd8) id_shift <= id_nx;
          if (byte_counter == 32'd3 && id_nx != wcsp_pkg::TAG_RIFF) hdr_bad <= 1'b1;
          if (byte_counter == 32'd11) byte_counter <= 32'd0;
        end
        wcsp_pkg::PH_CHUNK: begin
          if (byte_counter < 32'd4) id_shift <= id_nx;
          else chunk_length <= len_nx;
          if (byte_counter == 32'd7) begin
            byte_counter <= 32'd0;
            if (id_shift == wcsp_pkg::TAG_FMT) begin
              format_code <= 16'd0; channels_held <= 16'd0; rate_held <= 32'd0;
              align_held <= 16'd0; bits_held <= 16'd0;
              skip_left <= len_nx - wcsp_pkg::FMT_MIN_BYTES;
            end else if (id_shift != wcsp_pkg::TAG_DATA) begin
              skip_left <= len_nx;
            end
          end
        end
        wcsp_pkg::PH_FMT: begin
          case (byte_counter[3:0])
            4'd0:  format_code[7:0] <= data_byte;
            4'd1:  format_code[15:8] <= data_byte;
            4'd2:  channels_held[7:0] <= data_byte;
            4'd3:  channels_held[15:8] <= data_byte;
            4'd4:  rate_held[7:0] <= data_byte;
            4'd5:  rate_held[15:8] <= data_byte;
            4'd6:  rate_held[23:16] <= data_byte;
            4'd7:  rate_held[31:24] <= data_byte;
            4'd12: align_held[7:0] <= data_byte;
            4'd13: align_held[15:8] <= data_byte;
            4'd14: bits_held[7:0] <= data_byte;
            4'd15: bits_held[15:8] <= data_byte;
            default: ;
          endcase
          if (byte_counter[3:0] == 4'd15) byte_counter <= 32'd0;
        end
        wcsp_pkg::PH_SKIP: begin
          if (skip_left != 32'd0) skip_left <= skip_left - 32'd1;
          byte_counter <= 32'd0;
        end
        wcsp_pkg::PH_DATA: begin
          sample_shift <= ss_nx;
          if (fire && bc_inc >= {16'd0, align_held}) begin
            byte_counter <= 32'd0;
            if (samples_left != 32'd0) samples_left <= samples_left - 32'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/wcsp_ctrl.sv
`default_nettype none
module wcsp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             out_stall,
  input  wire logic             out_valid,
  input  wire wcsp_pkg::sts_t   sts,
  output wcsp_pkg::cmd_t        cmd,
  output wcsp_pkg::phase_t      phase,
  input  wire wcsp_pkg::phase_t phase_next,
  input  wire logic             fire,
  input  wire logic [2:0]       fire_err,
  input  wire logic             fire_report
);
  logic out_free, started, accept;
  wcsp_pkg::phase_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wcsp_pkg::PH_HDR;
      started <= 1'b0;
    end else begin
      phase <= state_next;
      started <= cmd.div_start ? 1'b1 : (cmd.emit_report ? 1'b0 : started);
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    cmd.err = fire_err;
    state_next = phase;
    in_stall = 1'b1;
    accept = 1'b0;
    case (phase)
      wcsp_pkg::PH_HALT: begin
        in_stall = 1'b0;
      end
      wcsp_pkg::PH_DIV: begin
        if (!started) begin
          cmd.div_start = 1'b1;
        end else if (!sts.div_busy && out_free) begin
          cmd.emit_report = fire_report;
          state_next = phase_next;
        end
      end
      default: begin
        in_stall = !out_free;
        accept = in_valid && out_free;
        if (accept) begin
          cmd.take = 1'b1;
          state_next = phase_next;
          if (fire) begin
            if (phase == wcsp_pkg::PH_DATA) cmd.emit_sample = 1'b1;
            else cmd.emit_error = 1'b1;
          end
        end
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/wave_chunk_stream_parser_top.sv
`default_nettype none
// Byte-serial RIFF/WAVE reader. One byte is taken per cycle while the output
// register is free; each data chunk start holds the input for the frame
// count division (32-step restoring divider) until it loads the stream
// report word. Samples follow: PCM as sign-extended Q1.15, float as raw bits.
// After an error word the block swallows every byte until reset.
module wave_chunk_stream_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [31:0]      sample_word,
  output logic [15:0]      audio_format,
  output logic [15:0]      channel_count,
  output logic [31:0]      rate_hz,
  output logic [31:0]      frame_count,
  output logic [2:0]       error_code
);
  wcsp_pkg::cmd_t   cmd;
  wcsp_pkg::sts_t   sts;
  wcsp_pkg::phase_t phase, phase_next;
  logic        fire, fire_report;
  logic [2:0]  fire_err;
  logic [31:0] sample_val, frames_d, rate_d, indet;
  logic [15:0] fmt_d, chan_d;

  assign cfg_ready = 1'b1;
  // hold the frame count register for indeterminate data sizes
  always_ff @(posedge clk) begin
    if (rst) indet <= wcsp_pkg::INDET_RESET;
    else if (cfg_valid) indet <= cfg_data;
  end

  wcsp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .sts(sts), .cmd(cmd),
    .phase(phase), .phase_next(phase_next), .fire(fire), .fire_err(fire_err),
    .fire_report(fire_report)
  );

  wcsp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .data_byte(data_byte),
    .indet_frames(indet), .phase(phase), .phase_next(phase_next),
    .fire(fire), .fire_err(fire_err), .fire_report(fire_report),
    .sample_val(sample_val), .fmt_o(fmt_d), .chan_o(chan_d), .rate_o(rate_d),
    .frames_o(frames_d)
  );

  // output word register: load on any emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sample || cmd.emit_report || cmd.emit_error) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sample || cmd.emit_report || cmd.emit_error) begin
      result_kind   <= cmd.emit_sample ? wcsp_pkg::KIND_SAMPLE :
                       (cmd.emit_report ? wcsp_pkg::KIND_REPORT : wcsp_pkg::KIND_ERROR);
      sample_word   <= cmd.emit_sample ? sample_val : 32'd0;
      audio_format  <= cmd.emit_report ? fmt_d : 16'd0;
      channel_count <= cmd.emit_report ? chan_d : 16'd0;
      rate_hz       <= cmd.emit_report ? rate_d : 32'd0;
      frame_count   <= cmd.emit_report ? frames_d : 32'd0;
      error_code    <= cmd.emit_error ? cmd.err : 3'd0;
    end
  end

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == wcsp_pkg::PH_HALT |=> phase == wcsp_pkg::PH_HALT) else $error("halt left");
  a_no_take_div: assert property (@(posedge clk) disable iff (rst)
    phase == wcsp_pkg::PH_DIV |-> in_stall) else $error("byte taken in div");
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_error |=> phase == wcsp_pkg::PH_HALT) else $error("error no halt");
`endif
endmodule
`default_nettype wire
